// ===== hdl/sdi_pkg.sv =====
package sdi_pkg;

    localparam int unsigned INIT_ATTEMPTS = 5;
    localparam int unsigned POLL_RETRIES  = 65535;
    localparam int unsigned LOOP_W        = 16;
    localparam int unsigned ATTEMPT_W     = 3;

    localparam logic [LOOP_W-1:0]    LOOP_INIT    = LOOP_W'(POLL_RETRIES);
    localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX  = ATTEMPT_W'(INIT_ATTEMPTS);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_GO_IDLE,
        PH_IF_COND,
        PH_H_APP,
        PH_H_OP,
        PH_READ_OCR,
        PH_P_APP,
        PH_P_OP,
        PH_MMC_OP,
        PH_BLOCKLEN,
        PH_TEST_STD,
        PH_TEST_HC,
        PH_CSD_STD,
        PH_CSD_HC
    } t_phase;

    typedef enum logic [1:0] {
        ACT_SEND   = 2'd0,
        ACT_DONE   = 2'd1,
        ACT_ABSENT = 2'd2,
        ACT_FAILED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        RESP_R1   = 2'd0,
        RESP_R1_4 = 2'd1,
        RESP_DATA = 2'd2
    } t_resp;

    typedef enum logic [1:0] {
        CARD_NONE = 2'd0,
        CARD_MMC  = 2'd1,
        CARD_SD   = 2'd2,
        CARD_SDHC = 2'd3
    } t_card;

    localparam logic       CMD_START    = 1'b0;
    localparam logic       CMD_RESPONSE = 1'b1;

    localparam logic [5:0] CMD0  = 6'd0;
    localparam logic [5:0] CMD1  = 6'd1;
    localparam logic [5:0] CMD8  = 6'd8;
    localparam logic [5:0] CMD9  = 6'd9;
    localparam logic [5:0] CMD16 = 6'd16;
    localparam logic [5:0] CMD17 = 6'd17;
    localparam logic [5:0] CMD41 = 6'd41;
    localparam logic [5:0] CMD55 = 6'd55;
    localparam logic [5:0] CMD58 = 6'd58;

    localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
    localparam logic [31:0] ARG_BLKLEN  = 32'd512;

    localparam logic [7:0] CRC_CMD8    = 8'h87;
    localparam logic [7:0] CRC_DEFAULT = 8'h95;

    localparam logic [7:0] R1_IDLE  = 8'h01;
    localparam logic [7:0] R1_READY = 8'h00;

endpackage

// ===== hdl/sd_spi_card_init_sequencer.sv =====
// SD/MMC SPI-mode init sequencer at the command level. A start transaction (command 0)
// polls card presence and, if no card is ready, launches CMD0; each response transaction
// (command 1) carries the reply to the last command and yields the next command to send
// or a final status (done, absent, failed) with card type and sector count. Every
// transaction produces one result except a response while idle, which produces none.
// Two register stages: the input register loads at acceptance and the decision stage loads
// the result register from it once the result register is free or its result is taken. A new
// transaction is taken every cycle; the only limit is output backpressure, which reaches
// o_stall combinationally.
module sd_spi_card_init_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic        i_card_present,
    input  logic [7:0]  i_resp_r1,
    input  logic [31:0] i_resp_tail,
    input  logic [47:0] i_csd_bytes,
    input  logic        i_token_seen,
    input  logic        i_timed_out,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_action,
    output logic [5:0]  o_cmd_index,
    output logic [31:0] o_cmd_arg,
    output logic [7:0]  o_cmd_crc,
    output logic [1:0]  o_resp_kind,
    output logic        o_slow_clock,
    output logic [1:0]  o_card_type,
    output logic [31:0] o_sector_count,
    output logic        o_media_changed
);
    import sdi_pkg::*;

    // input stage
    logic        r_in_valid;
    logic        r_command;
    logic        r_present;
    logic [7:0]  r_r1;
    logic [31:0] r_tail;
    logic [47:0] r_csd;
    logic        r_token;
    logic        r_timeout;

    // sequencer state
    t_phase                r_phase,   n_phase;
    logic [ATTEMPT_W-1:0]  r_attempt, n_attempt;
    logic [LOOP_W-1:0]     r_loop,    n_loop;
    logic                  r_is_sd,   n_is_sd;
    t_card                 r_kind,    n_kind;
    logic [31:0]           r_cap,     n_cap;
    logic                  r_ready,   n_ready;
    logic                  r_changed, n_changed;

    // result stage
    logic        r_out_valid;
    t_action     r_action;
    logic [5:0]  r_idx;
    logic [31:0] r_arg;
    logic [7:0]  r_crc;
    t_resp       r_resp;
    logic        r_slow;
    t_card       r_card;
    logic [31:0] r_sectors;
    logic        r_media;

    logic        advance;
    logic        in_accept;

    // decision
    logic        emit;
    t_action     act;
    logic [5:0]  s_idx;
    logic [31:0] s_arg;
    t_resp       s_resp;

    // CSD decode
    logic [3:0]  blk;
    logic [11:0] v1_c;
    logic [2:0]  v1_m;
    logic [12:0] v1_c1;
    logic [4:0]  v1_sh;
    logic [31:0] v1_sectors;
    logic [22:0] hc_c1;
    logic [32:0] hc_s;
    logic [31:0] hc_sectors;
    logic        csd_ok;
    logic [31:0] csd_sectors;
    logic        ocr_ok;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_command <= i_command;
            r_present <= i_card_present;
            r_r1      <= i_resp_r1;
            r_tail    <= i_resp_tail;
            r_csd     <= i_csd_bytes;
            r_token   <= i_token_seen;
            r_timeout <= i_timed_out;
        end
    end

    always_comb begin
        blk        = r_csd[43:40];
        v1_c       = {r_csd[33:32], r_csd[31:24], r_csd[23:22]};
        v1_m       = {r_csd[9:8], r_csd[7]};
        v1_c1      = {1'b0, v1_c} + 13'd1;
        // (m + 2) + (blk - 9), valid only when blk >= 9
        v1_sh      = 5'({2'b00, v1_m}) + 5'({1'b0, blk}) - 5'd7;
        v1_sectors = 32'(v1_c1) << v1_sh;
        hc_c1      = {1'b0, r_csd[29:24], r_csd[23:16], r_csd[15:8]} + 23'd1;
        hc_s       = {hc_c1, 10'b0};
        hc_sectors = hc_s[32] ? 32'hFFFF_FFFF : hc_s[31:0];
        if (r_phase == PH_CSD_HC) begin
            csd_ok      = (blk == 4'd9);
            csd_sectors = hc_sectors;
        end else begin
            csd_ok      = (blk >= 4'd9);
            csd_sectors = v1_sectors;
        end
        ocr_ok = (r_tail[15:8] == 8'h01) && (r_tail[7:0] == 8'hAA);
    end

    always_comb begin
        logic                 want_fail;
        logic                 want_plain;
        logic                 want_mmc;
        logic                 want_hcs;
        logic [LOOP_W-1:0]    hcs_loop;
        logic [LOOP_W-1:0]    dec_loop;
        logic [ATTEMPT_W-1:0] next_attempt;

        want_fail    = 1'b0;
        want_plain   = 1'b0;
        want_mmc     = 1'b0;
        want_hcs     = 1'b0;
        hcs_loop     = r_loop;
        dec_loop     = r_loop - LOOP_W'(1);
        next_attempt = r_attempt + ATTEMPT_W'(1);

        n_phase   = r_phase;
        n_attempt = r_attempt;
        n_loop    = r_loop;
        n_is_sd   = r_is_sd;
        n_kind    = r_kind;
        n_cap     = r_cap;
        n_ready   = r_ready;
        n_changed = r_changed;

        emit   = 1'b1;
        act    = ACT_SEND;
        s_idx  = CMD0;
        s_arg  = '0;
        s_resp = RESP_R1;

        if (r_command == CMD_START) begin
            if (!r_present) begin
                n_ready   = 1'b0;
                n_kind    = CARD_NONE;
                n_changed = 1'b0;
                n_cap     = '0;
                n_phase   = PH_IDLE;
                act       = ACT_ABSENT;
            end else if (r_ready) begin
                n_phase = PH_IDLE;
                act     = ACT_DONE;
            end else begin
                n_attempt = '0;
                n_is_sd   = 1'b0;
                n_phase   = PH_GO_IDLE;
                s_idx     = CMD0;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    emit = 1'b0;
                end
                PH_GO_IDLE: begin
                    if (r_r1 != R1_IDLE) begin
                        want_fail = 1'b1;
                    end else begin
                        n_phase = PH_IF_COND;
                        s_idx   = CMD8;
                        s_arg   = ARG_IF_COND;
                        s_resp  = RESP_R1_4;
                    end
                end
                PH_IF_COND: begin
                    if (r_r1 == R1_IDLE && ocr_ok) begin
                        want_hcs = 1'b1;
                        hcs_loop = LOOP_INIT;
                    end else begin
                        want_plain = 1'b1;
                    end
                end
                PH_H_APP: begin
                    if (r_r1 != R1_IDLE) begin
                        want_plain = 1'b1;
                    end else begin
                        n_phase = PH_H_OP;
                        s_idx   = CMD41;
                        s_arg   = ARG_HCS;
                    end
                end
                PH_H_OP: begin
                    if (r_r1 == R1_READY) begin
                        if (r_loop == '0) begin
                            want_plain = 1'b1;
                        end else begin
                            n_phase = PH_READ_OCR;
                            s_idx   = CMD58;
                            s_resp  = RESP_R1_4;
                        end
                    end else if (r_timeout) begin
                        want_plain = 1'b1;
                    end else begin
                        want_hcs = 1'b1;
                    end
                end
                PH_READ_OCR: begin
                    if (r_r1 != R1_READY) begin
                        want_plain = 1'b1;
                    end else if (r_tail[30]) begin
                        n_phase = PH_TEST_HC;
                        s_idx   = CMD17;
                        s_resp  = RESP_DATA;
                    end else begin
                        n_is_sd = 1'b1;
                        n_phase = PH_BLOCKLEN;
                        s_idx   = CMD16;
                        s_arg   = ARG_BLKLEN;
                    end
                end
                PH_P_APP: begin
                    if (r_r1 != R1_IDLE) begin
                        want_mmc = 1'b1;
                    end else begin
                        n_phase = PH_P_OP;
                        s_idx   = CMD41;
                    end
                end
                PH_P_OP: begin
                    if (r_r1 == R1_READY) begin
                        n_is_sd = 1'b1;
                        n_phase = PH_BLOCKLEN;
                        s_idx   = CMD16;
                        s_arg   = ARG_BLKLEN;
                    end else if (r_timeout) begin
                        want_mmc = 1'b1;
                    end else begin
                        n_loop = dec_loop;
                        if (dec_loop == '0) begin
                            want_mmc = 1'b1;
                        end else begin
                            n_phase = PH_P_APP;
                            s_idx   = CMD55;
                        end
                    end
                end
                PH_MMC_OP: begin
                    if (r_loop == '0 || r_timeout) begin
                        want_fail = 1'b1;
                    end else begin
                        n_loop = dec_loop;
                        if (r_r1 == R1_READY) begin
                            n_phase = PH_BLOCKLEN;
                            s_idx   = CMD16;
                            s_arg   = ARG_BLKLEN;
                        end else begin
                            n_phase = PH_MMC_OP;
                            s_idx   = CMD1;
                        end
                    end
                end
                PH_BLOCKLEN: begin
                    n_phase = PH_TEST_STD;
                    s_idx   = CMD17;
                    s_resp  = RESP_DATA;
                end
                PH_TEST_STD, PH_TEST_HC: begin
                    if (r_r1 != R1_READY || !r_token) begin
                        want_fail = 1'b1;
                    end else begin
                        n_phase = (r_phase == PH_TEST_HC) ? PH_CSD_HC : PH_CSD_STD;
                        s_idx   = CMD9;
                        s_resp  = RESP_DATA;
                    end
                end
                PH_CSD_STD, PH_CSD_HC: begin
                    if (r_r1 != R1_READY || !r_token || !csd_ok) begin
                        want_fail = 1'b1;
                    end else begin
                        if (r_phase == PH_CSD_HC) begin
                            n_kind = CARD_SDHC;
                        end else begin
                            n_kind = r_is_sd ? CARD_SD : CARD_MMC;
                        end
                        n_cap     = csd_sectors;
                        n_ready   = 1'b1;
                        n_changed = 1'b1;
                        n_phase   = PH_IDLE;
                        act       = ACT_DONE;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        // top of the CMD55/ACMD41 loop with HCS
        if (want_hcs) begin
            if (hcs_loop == '0 || r_timeout) begin
                want_plain = 1'b1;
            end else begin
                n_loop  = hcs_loop - LOOP_W'(1);
                n_phase = PH_H_APP;
                s_idx   = CMD55;
            end
        end

        if (want_plain) begin
            if (LOOP_INIT == '0) begin
                want_mmc = 1'b1;
            end else begin
                n_loop  = LOOP_INIT;
                n_phase = PH_P_APP;
                s_idx   = CMD55;
                s_arg   = '0;
                s_resp  = RESP_R1;
            end
        end

        if (want_mmc) begin
            n_loop  = LOOP_INIT;
            n_phase = PH_MMC_OP;
            s_idx   = CMD1;
            s_arg   = '0;
            s_resp  = RESP_R1;
        end

        if (want_fail) begin
            n_attempt = next_attempt;
            if (next_attempt >= ATTEMPT_MAX) begin
                n_phase = PH_IDLE;
                act     = ACT_FAILED;
            end else if (!r_present) begin
                n_ready   = 1'b0;
                n_kind    = CARD_NONE;
                n_changed = 1'b0;
                n_cap     = '0;
                n_phase   = PH_IDLE;
                act       = ACT_ABSENT;
            end else begin
                n_is_sd = 1'b0;
                n_phase = PH_GO_IDLE;
                s_idx   = CMD0;
                s_arg   = '0;
                s_resp  = RESP_R1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_attempt <= '0;
            r_loop    <= '0;
            r_is_sd   <= 1'b0;
            r_kind    <= CARD_NONE;
            r_cap     <= '0;
            r_ready   <= 1'b0;
            r_changed <= 1'b0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_attempt <= n_attempt;
            r_loop    <= n_loop;
            r_is_sd   <= n_is_sd;
            r_kind    <= n_kind;
            r_cap     <= n_cap;
            r_ready   <= n_ready;
            r_changed <= n_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_action  <= act;
            r_card    <= n_kind;
            r_sectors <= n_cap;
            r_media   <= n_changed;
            if (act == ACT_SEND) begin
                r_idx  <= s_idx;
                r_arg  <= s_arg;
                r_crc  <= (s_idx == CMD8) ? CRC_CMD8 : CRC_DEFAULT;
                r_resp <= s_resp;
                r_slow <= 1'b1;
            end else begin
                r_idx  <= '0;
                r_arg  <= '0;
                r_crc  <= '0;
                r_resp <= RESP_R1;
                r_slow <= (act == ACT_ABSENT);
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_action        = r_action;
    assign o_cmd_index     = r_idx;
    assign o_cmd_arg       = r_arg;
    assign o_cmd_crc       = r_crc;
    assign o_resp_kind     = r_resp;
    assign o_slow_clock    = r_slow;
    assign o_card_type     = r_card;
    assign o_sector_count  = r_sectors;
    assign o_media_changed = r_media;

endmodule

// ===== hdl/sdi_checker.sv =====
module sdi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_action,
    input logic [5:0]  o_cmd_index,
    input logic [31:0] o_cmd_arg,
    input logic [7:0]  o_cmd_crc,
    input logic [1:0]  o_resp_kind,
    input logic        o_slow_clock,
    input logic [1:0]  o_card_type,
    input logic [31:0] o_sector_count,
    input logic        o_media_changed
);
    import sdi_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_action) && $stable(o_cmd_index)
            && $stable(o_cmd_arg) && $stable(o_sector_count))
        else $error("result changed while stalled");

    // status results carry no command frame
    a_status_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action != ACT_SEND |-> o_cmd_index == '0 && o_cmd_arg == '0
            && o_cmd_crc == '0 && o_resp_kind == RESP_R1)
        else $error("status result with command fields");

    a_send_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_SEND |-> o_slow_clock
            && (o_cmd_crc == ((o_cmd_index == CMD8) ? CRC_CMD8 : CRC_DEFAULT)))
        else $error("bad command framing");

    a_absent_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_ABSENT |-> o_card_type == CARD_NONE
            && o_sector_count == '0 && !o_media_changed)
        else $error("card state kept after removal");

    a_done_card: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_action == ACT_DONE |-> o_media_changed && o_card_type != CARD_NONE
            && !o_slow_clock)
        else $error("init done without card data");

endmodule

bind sd_spi_card_init_sequencer sdi_checker u_sdi_checker (.*);

// ===== tb/tb_sd_spi_card_init_sequencer.sv =====
`timescale 1ns / 1ps

module tb_sd_spi_card_init_sequencer;
    import sdi_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic        command;
        logic        present;
        logic [7:0]  r1;
        logic [31:0] tail;
        logic [47:0] csd;
        logic        token;
        logic        timeout;
    } t_card_item;

    typedef struct packed {
        t_action     action;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic [7:0]  cmd_crc;
        t_resp       resp_kind;
        logic        slow_clock;
        t_card       card_type;
        logic [31:0] sector_count;
        logic        media_changed;
    } t_card_reply;

    typedef struct packed {
        t_card_item  it;
        logic        typed;
        t_card_reply want;
    } t_init_step;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_command;
    logic        i_card_present;
    logic [7:0]  i_resp_r1;
    logic [31:0] i_resp_tail;
    logic [47:0] i_csd_bytes;
    logic        i_token_seen;
    logic        i_timed_out;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_action;
    logic [5:0]  o_cmd_index;
    logic [31:0] o_cmd_arg;
    logic [7:0]  o_cmd_crc;
    logic [1:0]  o_resp_kind;
    logic        o_slow_clock;
    logic [1:0]  o_card_type;
    logic [31:0] o_sector_count;
    logic        o_media_changed;

    sd_spi_card_init_sequencer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_card_present  (i_card_present),
        .i_resp_r1       (i_resp_r1),
        .i_resp_tail     (i_resp_tail),
        .i_csd_bytes     (i_csd_bytes),
        .i_token_seen    (i_token_seen),
        .i_timed_out     (i_timed_out),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_action        (o_action),
        .o_cmd_index     (o_cmd_index),
        .o_cmd_arg       (o_cmd_arg),
        .o_cmd_crc       (o_cmd_crc),
        .o_resp_kind     (o_resp_kind),
        .o_slow_clock    (o_slow_clock),
        .o_card_type     (o_card_type),
        .o_sector_count  (o_sector_count),
        .o_media_changed (o_media_changed)
    );

    // shadow of the sequencer state, advanced once per driven transaction
    t_phase      ph;
    logic [2:0]  tries;
    logic [15:0] poll_left;
    logic        sd_flag;
    t_card       card_kind;
    logic [31:0] sectors;
    logic        ready;
    logic        changed;
    logic        cur_present;
    logic        cur_timeout;

    t_card_reply pending_replies[$];
    t_init_step  init_steps[$];
    t_card_reply no_reply;
    int          mismatches;
    int          quiet;
    int          tx_mode;
    int          rx_mode;
    int          flaky;
    bit          rx_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_card_reply make_reply(t_action act, logic [5:0] idx,
                                               logic [31:0] arg, t_resp kind);
        t_card_reply r;
        r.action        = act;
        r.cmd_index     = idx;
        r.cmd_arg       = arg;
        r.cmd_crc       = (act == ACT_SEND) ? ((idx == CMD8) ? CRC_CMD8 : CRC_DEFAULT) : 8'h00;
        r.resp_kind     = kind;
        r.slow_clock    = (act == ACT_SEND || act == ACT_ABSENT);
        r.card_type     = card_kind;
        r.sector_count  = sectors;
        r.media_changed = changed;
        return r;
    endfunction

    function automatic t_card_reply issue(t_phase nxt, logic [5:0] idx, logic [31:0] arg,
                                          t_resp kind);
        ph = nxt;
        return make_reply(ACT_SEND, idx, arg, kind);
    endfunction

    function automatic void drop_card();
        ready     = 1'b0;
        card_kind = CARD_NONE;
        changed   = 1'b0;
        sectors   = '0;
    endfunction

    function automatic t_card_reply new_attempt();
        sd_flag = 1'b0;
        return issue(PH_GO_IDLE, CMD0, '0, RESP_R1);
    endfunction

    function automatic t_card_reply attempt_failed();
        tries = tries + 3'd1;
        if (tries >= ATTEMPT_MAX) begin
            ph = PH_IDLE;
            return make_reply(ACT_FAILED, '0, '0, RESP_R1);
        end
        if (!cur_present) begin
            drop_card();
            ph = PH_IDLE;
            return make_reply(ACT_ABSENT, '0, '0, RESP_R1);
        end
        return new_attempt();
    endfunction

    function automatic t_card_reply start_mmc();
        poll_left = LOOP_INIT;
        return issue(PH_MMC_OP, CMD1, '0, RESP_R1);
    endfunction

    function automatic t_card_reply start_plain();
        poll_left = LOOP_INIT;
        if (poll_left == '0)
            return start_mmc();
        return issue(PH_P_APP, CMD55, '0, RESP_R1);
    endfunction

    function automatic t_card_reply hcs_loop_top();
        if (poll_left == '0)
            return start_plain();
        poll_left = poll_left - 16'd1;
        if (cur_timeout)
            return start_plain();
        return issue(PH_H_APP, CMD55, '0, RESP_R1);
    endfunction

    function automatic t_card_reply test_read(logic hc);
        return issue(hc ? PH_TEST_HC : PH_TEST_STD, CMD17, '0, RESP_DATA);
    endfunction

    function automatic void advance_sequencer(input t_card_item it, output bit has,
                                              output t_card_reply r);
        logic        hc;
        logic        ok;
        logic [3:0]  blk;
        logic [63:0] big;
        logic [11:0] csize;
        logic [2:0]  mult;
        logic [31:0] cap;
        has = 1'b1;
        r = no_reply;
        cur_present = it.present;
        cur_timeout = it.timeout;
        if (it.command == CMD_START) begin
            if (!cur_present) begin
                drop_card();
                ph = PH_IDLE;
                r = make_reply(ACT_ABSENT, '0, '0, RESP_R1);
            end else if (ready) begin
                ph = PH_IDLE;
                r = make_reply(ACT_DONE, '0, '0, RESP_R1);
            end else begin
                tries = '0;
                r = new_attempt();
            end
            return;
        end
        case (ph)
            PH_GO_IDLE: begin
                if (it.r1 != R1_IDLE) r = attempt_failed();
                else r = issue(PH_IF_COND, CMD8, ARG_IF_COND, RESP_R1_4);
            end
            PH_IF_COND: begin
                if (it.r1 == R1_IDLE && it.tail[15:8] == 8'h01 && it.tail[7:0] == 8'hAA) begin
                    poll_left = LOOP_INIT;
                    r = hcs_loop_top();
                end else begin
                    r = start_plain();
                end
            end
            PH_H_APP: begin
                if (it.r1 != R1_IDLE) r = start_plain();
                else r = issue(PH_H_OP, CMD41, ARG_HCS, RESP_R1);
            end
            PH_H_OP: begin
                if (it.r1 == R1_READY) begin
                    // success on the last count still counts as a failed loop
                    if (poll_left == '0) r = start_plain();
                    else r = issue(PH_READ_OCR, CMD58, '0, RESP_R1_4);
                end else if (cur_timeout) begin
                    r = start_plain();
                end else begin
                    r = hcs_loop_top();
                end
            end
            PH_READ_OCR: begin
                if (it.r1 != R1_READY) begin
                    r = start_plain();
                end else if (it.tail[30]) begin
                    r = test_read(1'b1);
                end else begin
                    sd_flag = 1'b1;
                    r = issue(PH_BLOCKLEN, CMD16, ARG_BLKLEN, RESP_R1);
                end
            end
            PH_P_APP: begin
                if (it.r1 != R1_IDLE) r = start_mmc();
                else r = issue(PH_P_OP, CMD41, '0, RESP_R1);
            end
            PH_P_OP: begin
                if (it.r1 == R1_READY) begin
                    sd_flag = 1'b1;
                    r = issue(PH_BLOCKLEN, CMD16, ARG_BLKLEN, RESP_R1);
                end else if (cur_timeout) begin
                    r = start_mmc();
                end else begin
                    poll_left = poll_left - 16'd1;
                    if (poll_left == '0) r = start_mmc();
                    else r = issue(PH_P_APP, CMD55, '0, RESP_R1);
                end
            end
            PH_MMC_OP: begin
                if (poll_left == '0 || cur_timeout) begin
                    r = attempt_failed();
                end else begin
                    poll_left = poll_left - 16'd1;
                    if (it.r1 == R1_READY) r = issue(PH_BLOCKLEN, CMD16, ARG_BLKLEN, RESP_R1);
                    else r = issue(PH_MMC_OP, CMD1, '0, RESP_R1);
                end
            end
            PH_BLOCKLEN: r = test_read(1'b0);
            PH_TEST_STD, PH_TEST_HC: begin
                if (it.r1 != R1_READY || !it.token) r = attempt_failed();
                else r = issue((ph == PH_TEST_HC) ? PH_CSD_HC : PH_CSD_STD, CMD9, '0, RESP_DATA);
            end
            PH_CSD_STD, PH_CSD_HC: begin
                hc  = (ph == PH_CSD_HC);
                blk = it.csd[43:40];
                if (hc) begin
                    big = ({42'd0, it.csd[29:24], it.csd[23:16], it.csd[15:8]} + 64'd1) << 10;
                    ok  = (blk == 4'd9);
                    cap = (big > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : big[31:0];
                end else begin
                    csize = {it.csd[33:32], it.csd[31:24], it.csd[23:22]};
                    mult  = {it.csd[9:8], it.csd[7]};
                    ok    = (blk >= 4'd9);
                    cap   = ((32'(csize) + 32'd1) << (32'(mult) + 32'd2)) << (32'(blk) - 32'd9);
                end
                if (it.r1 != R1_READY || !it.token || !ok) begin
                    r = attempt_failed();
                end else begin
                    card_kind = hc ? CARD_SDHC : (sd_flag ? CARD_SD : CARD_MMC);
                    sectors   = cap;
                    ready     = 1'b1;
                    changed   = 1'b1;
                    ph        = PH_IDLE;
                    r = make_reply(ACT_DONE, '0, '0, RESP_R1);
                end
            end
            default: has = 1'b0;   // response while idle is dropped
        endcase
    endfunction

    function automatic t_card_item mk_item(logic cmd, logic pres, logic [7:0] r1,
                                           logic [31:0] tail, logic [47:0] csd,
                                           logic tok, logic tmo);
        t_card_item it;
        it.command = cmd;
        it.present = pres;
        it.r1      = r1;
        it.tail    = tail;
        it.csd     = csd;
        it.token   = tok;
        it.timeout = tmo;
        return it;
    endfunction

    function automatic t_card_reply reply(t_action act, logic [5:0] idx, logic [31:0] arg,
                                          logic [7:0] crc, t_resp kind, logic slow,
                                          t_card ct, logic [31:0] n, logic chg);
        t_card_reply r;
        r.action        = act;
        r.cmd_index     = idx;
        r.cmd_arg       = arg;
        r.cmd_crc       = crc;
        r.resp_kind     = kind;
        r.slow_clock    = slow;
        r.card_type     = ct;
        r.sector_count  = n;
        r.media_changed = chg;
        return r;
    endfunction

    function automatic void add_step(t_card_item it, logic typed, t_card_reply want);
        t_init_step s;
        s.it    = it;
        s.typed = typed;
        s.want  = want;
        init_steps.push_back(s);
    endfunction

    function automatic int pause_len(int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < ((mode == 1) ? 70 : 40)) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // replies to whatever the sequencer last asked for, well-formed with the chance set by flaky
    function automatic t_card_item rand_item();
        t_card_item it;
        bit good;
        it.command = CMD_RESPONSE;
        it.present = ($urandom_range(0, 39) != 0);
        it.r1      = 8'($urandom);
        it.tail    = $urandom;
        it.csd     = {16'($urandom), 32'($urandom)};
        it.token   = 1'($urandom);
        it.timeout = ($urandom_range(0, 29) == 0);
        if ($urandom_range(0, 9) == 0) begin
            it.command = 1'($urandom);
            it.present = 1'($urandom);
            it.timeout = 1'($urandom);
            return it;
        end
        good = ($urandom_range(0, 99) < flaky);
        case (ph)
            PH_IDLE: begin
                it.command = CMD_START;
                if (ready) it.present = 1'($urandom);
            end
            PH_GO_IDLE, PH_H_APP, PH_P_APP: if (good) it.r1 = R1_IDLE;
            PH_IF_COND: begin
                if (good) begin
                    it.r1         = R1_IDLE;
                    it.tail[15:0] = 16'h01AA;
                end
            end
            PH_H_OP: if (good) it.r1 = ($urandom_range(0, 2) == 0) ? R1_IDLE : R1_READY;
            PH_P_OP, PH_MMC_OP: if (good) it.r1 = 1'($urandom) ? R1_IDLE : R1_READY;
            PH_READ_OCR: if (good) it.r1 = R1_READY;
            PH_TEST_STD, PH_TEST_HC: begin
                if (good) begin
                    it.r1    = R1_READY;
                    it.token = 1'b1;
                end
            end
            PH_CSD_STD, PH_CSD_HC: begin
                if (good) begin
                    it.r1         = R1_READY;
                    it.token      = 1'b1;
                    it.csd[43:40] = (ph == PH_CSD_HC) ? 4'd9 : 4'($urandom_range(9, 15));
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic send_item(input t_card_item it, input logic typed, input t_card_reply want,
                             output bit has);
        t_card_reply r;
        int g;
        advance_sequencer(it, has, r);
        if (has)
            pending_replies.push_back(typed ? want : r);
        g = pause_len(tx_mode);
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= it.command;
        i_card_present <= it.present;
        i_resp_r1      <= it.r1;
        i_resp_tail    <= it.tail;
        i_csd_bytes    <= it.csd;
        i_token_seen   <= it.token;
        i_timed_out    <= it.timeout;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : reply_check
        t_card_reply e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected transaction: action %0d cmd %0d", o_action, o_cmd_index);
                mismatches++;
            end else begin
                e = pending_replies.pop_front();
                check_field("action", 32'(e.action), 32'(o_action));
                check_field("cmd_index", 32'(e.cmd_index), 32'(o_cmd_index));
                check_field("cmd_arg", e.cmd_arg, o_cmd_arg);
                check_field("cmd_crc", 32'(e.cmd_crc), 32'(o_cmd_crc));
                check_field("resp_kind", 32'(e.resp_kind), 32'(o_resp_kind));
                check_field("slow_clock", 32'(e.slow_clock), 32'(o_slow_clock));
                check_field("card_type", 32'(e.card_type), 32'(o_card_type));
                check_field("sector_count", e.sector_count, o_sector_count);
                check_field("media_changed", 32'(e.media_changed), 32'(o_media_changed));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("tb_sd_spi_card_init_sequencer: FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // result side: random stall, plus one long hold-off on request
    initial begin : rx_side
        int n;
        bit hold_done;
        i_stall <= 1'b0;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req && !hold_done) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_done = 1'b1;
            end else begin
                n = pause_len(rx_mode);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                    i_stall <= 1'b0;
                end
            end
            @(posedge i_clk);
        end
    end

    initial begin : tx_side
        t_card_reply none_r;
        bit has;
        bit paused;
        bit held;
        int n_done;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_command      <= CMD_START;
        i_card_present <= 1'b0;
        i_resp_r1      <= '0;
        i_resp_tail    <= '0;
        i_csd_bytes    <= '0;
        i_token_seen   <= 1'b0;
        i_timed_out    <= 1'b0;
        rx_hold_req = 1'b0;
        tx_mode     = 1;
        rx_mode     = 1;
        flaky       = 90;
        no_reply    = '0;
        none_r      = '0;
        ph          = PH_IDLE;
        tries       = '0;
        poll_left   = '0;
        sd_flag     = 1'b0;
        drop_card();

        // start without a card, then a stray response while idle
        add_step(mk_item(CMD_START, 1'b0, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1),
                 1'b1, reply(ACT_ABSENT, '0, '0, 8'h00, RESP_R1, 1'b1, CARD_NONE, '0, 1'b0));
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_READY, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_START, 1'b1, '0, '0, '0, 1'b0, 1'b0), 1'b1,
                 reply(ACT_SEND, CMD0, '0, CRC_DEFAULT, RESP_R1, 1'b1, CARD_NONE, '0, 1'b0));
        // start again mid-sequence restarts the attempt count
        add_step(mk_item(CMD_START, 1'b1, '0, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_IDLE, '0, '0, 1'b0, 1'b0), 1'b1,
                 reply(ACT_SEND, CMD8, ARG_IF_COND, CRC_CMD8, RESP_R1_4, 1'b1, CARD_NONE, '0,
                       1'b0));
        // v1 SD path, CSD with block length 8 fails
        add_step(mk_item(CMD_RESPONSE, 1'b1, 8'h05, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_IDLE, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_READY, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
                         1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_READY, '0, '0, 1'b1, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_READY, '0, 48'h08FF_FFFF_FFFF, 1'b1, 1'b0),
                 1'b0, none_r);
        // MMC path, CMD1 ready but timed out
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_IDLE, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, 8'h04, 32'h0000_01AA, '0, 1'b0, 1'b0), 1'b0,
                 none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, 8'h04, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_READY, '0, '0, 1'b0, 1'b1), 1'b0, none_r);
        // burn the remaining attempts
        add_step(mk_item(CMD_RESPONSE, 1'b1, 8'hFF, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, 8'hFF, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, 8'hFF, '0, '0, 1'b0, 1'b0), 1'b1,
                 reply(ACT_FAILED, '0, '0, 8'h00, RESP_R1, 1'b0, CARD_NONE, '0, 1'b0));
        // SDHC path with maximum C_SIZE, capacity saturates
        add_step(mk_item(CMD_START, 1'b1, '0, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_IDLE, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_IDLE, 32'h0000_01AA, '0, 1'b0, 1'b0), 1'b0,
                 none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_IDLE, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_READY, '0, '0, 1'b0, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_READY, 32'hFFFF_FFFF, '0, 1'b0, 1'b0), 1'b0,
                 none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_READY, '0, '0, 1'b1, 1'b0), 1'b0, none_r);
        add_step(mk_item(CMD_RESPONSE, 1'b1, R1_READY, '0, 48'h09FF_FFFF_FFFF, 1'b1, 1'b0),
                 1'b1, reply(ACT_DONE, '0, '0, 8'h00, RESP_R1, 1'b0, CARD_SDHC, 32'hFFFF_FFFF,
                             1'b1));
        // start with the card already up reports the stored data
        add_step(mk_item(CMD_START, 1'b1, '0, '0, '0, 1'b0, 1'b0), 1'b1,
                 reply(ACT_DONE, '0, '0, 8'h00, RESP_R1, 1'b0, CARD_SDHC, 32'hFFFF_FFFF, 1'b1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (init_steps[k])
            send_item(init_steps[k].it, init_steps[k].typed, init_steps[k].want, has);

        n_done = 0;
        paused = 1'b0;
        held   = 1'b0;
        while (n_done < RANDOM_ITEMS) begin
            if (n_done % 100 == 0) begin
                tx_mode = $urandom_range(0, 2);
                rx_mode = $urandom_range(0, 2);
                flaky   = ($urandom_range(0, 3) == 0) ? 40 : 90;
            end
            if (n_done == 400 && !paused) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_replies.size() != 0);
            end
            if (n_done == 700 && !held) begin
                held = 1'b1;
                tx_mode = 0;
                rx_hold_req = 1'b1;
            end
            send_item(rand_item(), 1'b0, none_r, has);
            if (has)
                n_done++;
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_sd_spi_card_init_sequencer: PASS");
        else
            $display("tb_sd_spi_card_init_sequencer: FAIL");
        $finish;
    end

endmodule
